/* design/addressable_led_strip_driver_assert.svh */
// Assertion macros for the LED strip driver.
// Used by addressable_led_strip_driver.sv; expects clk and rst_n in scope.
`ifndef ADDRESSABLE_LED_STRIP_DRIVER_ASSERT_SVH
`define ADDRESSABLE_LED_STRIP_DRIVER_ASSERT_SVH
`ifndef SYNTHESIS
`define ALSD_ASSERT_IMP(lbl, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("alsd: same-cycle check failed");
`define ALSD_ASSERT_NXT(lbl, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("alsd: next-cycle check failed");
`else
`define ALSD_ASSERT_IMP(lbl, a, b)
`define ALSD_ASSERT_NXT(lbl, a, b)
`endif
`endif

/* design/alsd_pkg.sv */
// Shared types, codes and helpers for the LED strip driver.
// No dependencies; used by alsd_ctrl, alsd_dpath and the top level.
package alsd_pkg;

    typedef enum logic [1:0] {
        REQ_SET   = 2'd0,
        REQ_CLEAR = 2'd1,
        REQ_SHOW  = 2'd2,
        REQ_TICK  = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_INDEX = 2'd1,
        ST_REFUSED   = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_HIGH  = 2'd1,
        PH_LOW   = 2'd2,
        PH_LATCH = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        SEL_RED   = 2'd0,
        SEL_GREEN = 2'd1,
        SEL_BLUE  = 2'd2
    } color_sel_t;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_SET_R,
        S_SET_G,
        S_SET_B,
        S_CLEAR,
        S_FETCH,
        S_LOAD,
        S_DONE
    } ctrl_state_t;

    // register indexes on the config port
    localparam logic [2:0] REG_STRIP_LENGTH = 3'd0;
    localparam logic [2:0] REG_COLOR_ORDER  = 3'd1;
    localparam logic [2:0] REG_ZERO_HIGH    = 3'd2;
    localparam logic [2:0] REG_ZERO_LOW     = 3'd3;
    localparam logic [2:0] REG_ONE_HIGH     = 3'd4;
    localparam logic [2:0] REG_ONE_LOW      = 3'd5;
    localparam logic [2:0] REG_LATCH        = 3'd6;

    localparam logic [8:0]  RST_STRIP_LENGTH = 9'd256;
    localparam logic [5:0]  RST_COLOR_ORDER  = 6'd6;
    localparam logic [15:0] RST_ZERO_HIGH    = 16'd40;
    localparam logic [15:0] RST_ZERO_LOW     = 16'd85;
    localparam logic [15:0] RST_ONE_HIGH     = 16'd80;
    localparam logic [15:0] RST_ONE_LOW      = 16'd45;
    localparam logic [15:0] RST_LATCH        = 16'd6000;

    localparam logic [2:0] BIT_MSB = 3'd7;
    localparam logic [1:0] SLOT_LAST = 2'd2;

    typedef struct packed {
        logic       accept;
        logic       tick;
        logic       show;
        logic       rd;
        logic       load;
        logic       wr_set;
        color_sel_t wr_sel;
        logic       clr_step;
        logic       clr_all;
        logic       emit;
    } cmd_t;

    typedef struct packed {
        logic busy;
        logic idx_bad;
        logic n_zero;
        logic need_fetch;
        logic clr_last;
        logic out_free;
    } stat_t;

    // color offset of three is used as two
    function automatic logic [1:0] sat_off(input logic [1:0] o);
        return (o == 2'd3) ? 2'd2 : o;
    endfunction

    // zero timing is used as one tick
    function automatic logic [15:0] at_least_one(input logic [15:0] t);
        return (t == 16'd0) ? 16'd1 : t;
    endfunction

endpackage

/* design/alsd_ctrl.sv */
// Controller state machine for the LED strip driver.
// Depends on alsd_pkg; drives alsd_dpath through cmd_t, reads stat_t.
module alsd_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic [1:0]          in_req,
    output logic                in_ready,
    input  alsd_pkg::stat_t     stat,
    output alsd_pkg::cmd_t      cmd
);

    alsd_pkg::ctrl_state_t state_reg;
    alsd_pkg::ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= alsd_pkg::S_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        cmd.wr_sel = alsd_pkg::SEL_RED;
        state_next = state_reg;
        in_ready   = 1'b0;
        case (state_reg)
            alsd_pkg::S_INIT:
            begin
                // store clearing pass after reset
                cmd.clr_step = 1'b1;
                cmd.clr_all  = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = alsd_pkg::S_IDLE;
                end
            end
            alsd_pkg::S_IDLE:
            begin
                in_ready = stat.out_free;
                if (in_valid && stat.out_free)
                begin
                    cmd.accept = 1'b1;
                    if (alsd_pkg::req_t'(in_req) == alsd_pkg::REQ_TICK)
                    begin
                        cmd.tick = 1'b1;
                        if (stat.need_fetch)
                        begin
                            state_next = alsd_pkg::S_FETCH;
                        end
                        else
                        begin
                            cmd.emit = 1'b1;
                        end
                    end
                    else if (stat.busy)
                    begin
                        cmd.emit = 1'b1;
                    end
                    else
                    begin
                        case (alsd_pkg::req_t'(in_req))
                            alsd_pkg::REQ_SET:
                            begin
                                if (stat.idx_bad)
                                begin
                                    cmd.emit = 1'b1;
                                end
                                else
                                begin
                                    state_next = alsd_pkg::S_SET_R;
                                end
                            end
                            alsd_pkg::REQ_CLEAR:
                            begin
                                if (stat.n_zero)
                                begin
                                    cmd.emit = 1'b1;
                                end
                                else
                                begin
                                    state_next = alsd_pkg::S_CLEAR;
                                end
                            end
                            alsd_pkg::REQ_SHOW:
                            begin
                                cmd.show = 1'b1;
                                if (stat.n_zero)
                                begin
                                    cmd.emit = 1'b1;
                                end
                                else
                                begin
                                    state_next = alsd_pkg::S_FETCH;
                                end
                            end
                            default:
                            begin
                                cmd.emit = 1'b1;
                            end
                        endcase
                    end
                end
            end
            alsd_pkg::S_SET_R:
            begin
                cmd.wr_set = 1'b1;
                cmd.wr_sel = alsd_pkg::SEL_RED;
                state_next = alsd_pkg::S_SET_G;
            end
            alsd_pkg::S_SET_G:
            begin
                cmd.wr_set = 1'b1;
                cmd.wr_sel = alsd_pkg::SEL_GREEN;
                state_next = alsd_pkg::S_SET_B;
            end
            alsd_pkg::S_SET_B:
            begin
                cmd.wr_set = 1'b1;
                cmd.wr_sel = alsd_pkg::SEL_BLUE;
                state_next = alsd_pkg::S_DONE;
            end
            alsd_pkg::S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = alsd_pkg::S_DONE;
                end
            end
            alsd_pkg::S_FETCH:
            begin
                cmd.rd     = 1'b1;
                state_next = alsd_pkg::S_LOAD;
            end
            alsd_pkg::S_LOAD:
            begin
                cmd.load   = 1'b1;
                state_next = alsd_pkg::S_DONE;
            end
            alsd_pkg::S_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = alsd_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = alsd_pkg::S_IDLE;
            end
        endcase
    end

endmodule

/* design/alsd_dpath.sv */
// Datapath for the LED strip driver: config registers, pixel store,
// bit/phase timing and the result register. Depends on alsd_pkg.
module alsd_dpath #(
    parameter int MAX_LEDS = 256
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    input  logic [2:0]          cfg_index,
    input  logic [15:0]         cfg_data,
    input  logic [1:0]          in_req,
    input  logic [15:0]         in_index,
    input  logic [7:0]          in_red,
    input  logic [7:0]          in_green,
    input  logic [7:0]          in_blue,
    input  alsd_pkg::cmd_t      cmd,
    output alsd_pkg::stat_t     stat,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                out_line,
    output logic                out_busy,
    output logic [1:0]          out_status
);

    localparam int MEM_DEPTH = MAX_LEDS * 3;
    localparam int AW        = $clog2(MEM_DEPTH);
    localparam int LW        = $clog2(MAX_LEDS + 1);

    // config registers
    logic [8:0]  strip_length_reg;
    logic [5:0]  color_order_reg;
    logic [15:0] zero_high_reg;
    logic [15:0] zero_low_reg;
    logic [15:0] one_high_reg;
    logic [15:0] one_low_reg;
    logic [15:0] latch_reg;

    // send state
    alsd_pkg::phase_t phase_reg, phase_next;
    logic [15:0]      timer_reg, timer_next;
    logic [2:0]       bit_reg, bit_next;
    logic [LW-1:0]    led_reg, led_next;
    logic [1:0]       slot_reg, slot_next;
    logic [7:0]       shift_reg, shift_next;

    // latched request and misc
    logic [LW-1:0]    idx_reg;
    logic [7:0]       red_reg, green_reg, blue_reg;
    logic [1:0]       status_reg;
    logic [AW-1:0]    clr_ptr_reg;
    logic [7:0]       rd_data_reg;
    logic             out_valid_reg;
    logic             out_line_reg;
    logic             out_busy_reg;
    logic [1:0]       out_status_reg;

    logic [7:0]       mem [MEM_DEPTH];

    logic [LW-1:0]    n_eff;
    logic [1:0]       off_r, off_g, off_b, fetch_off, wr_off;
    logic [15:0]      t1;
    logic [LW-1:0]    led_inc;
    logic [1:0]       slot_inc;
    logic             cur_bit;
    logic [AW+1:0]    fetch_sum, base_sum;
    logic [AW-1:0]    fetch_addr, clr_end;
    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    logic [7:0]       wr_data;
    logic [1:0]       status_now;

    always_comb
    begin
        if (int'(strip_length_reg) > MAX_LEDS)
        begin
            n_eff = LW'(MAX_LEDS);
        end
        else
        begin
            n_eff = LW'(strip_length_reg);
        end
    end

    assign off_r = alsd_pkg::sat_off(color_order_reg[5:4]);
    assign off_g = alsd_pkg::sat_off(color_order_reg[3:2]);
    assign off_b = alsd_pkg::sat_off(color_order_reg[1:0]);

    assign t1       = (timer_reg != 16'd0) ? timer_reg - 16'd1 : 16'd0;
    assign led_inc  = (slot_reg == alsd_pkg::SLOT_LAST) ? led_reg + LW'(1) : led_reg;
    assign slot_inc = (slot_reg == alsd_pkg::SLOT_LAST) ? 2'd0 : slot_reg + 2'd1;
    assign cur_bit  = shift_reg[bit_reg];

    // status to controller
    assign stat.busy       = (phase_reg != alsd_pkg::PH_IDLE);
    assign stat.idx_bad    = (32'(in_index) >= 32'(n_eff));
    assign stat.n_zero     = (n_eff == '0);
    assign stat.need_fetch = (phase_reg == alsd_pkg::PH_LOW) && (t1 == 16'd0)
                             && (bit_reg == 3'd0) && (led_inc < n_eff);
    assign clr_end         = cmd.clr_all ? AW'(MEM_DEPTH - 1) : AW'(3 * int'(n_eff) - 1);
    assign stat.clr_last   = (clr_ptr_reg == clr_end);
    assign stat.out_free   = !out_valid_reg || out_ready;

    // slot order on the wire: G, R, B
    always_comb
    begin
        case (slot_reg)
            2'd0:    fetch_off = off_g;
            2'd1:    fetch_off = off_r;
            default: fetch_off = off_b;
        endcase
    end

    // led*3 as shift and add
    assign fetch_sum  = (AW+2)'(led_reg) + ((AW+2)'(led_reg) << 1) + (AW+2)'(fetch_off);
    assign fetch_addr = fetch_sum[AW-1:0];

    always_comb
    begin
        case (cmd.wr_sel)
            alsd_pkg::SEL_RED:   wr_off = off_r;
            alsd_pkg::SEL_GREEN: wr_off = off_g;
            default:             wr_off = off_b;
        endcase
    end
    assign base_sum = (AW+2)'(idx_reg) + ((AW+2)'(idx_reg) << 1) + (AW+2)'(wr_off);

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = clr_ptr_reg;
        wr_data = 8'd0;
        if (cmd.clr_step)
        begin
            wr_en = 1'b1;
        end
        else if (cmd.wr_set)
        begin
            wr_en   = 1'b1;
            wr_addr = base_sum[AW-1:0];
            case (cmd.wr_sel)
                alsd_pkg::SEL_RED:   wr_data = red_reg;
                alsd_pkg::SEL_GREEN: wr_data = green_reg;
                default:             wr_data = blue_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd)
        begin
            rd_data_reg <= mem[fetch_addr];
        end
    end

    // phase and bit sequencing
    always_comb
    begin
        phase_next = phase_reg;
        timer_next = timer_reg;
        bit_next   = bit_reg;
        led_next   = led_reg;
        slot_next  = slot_reg;
        shift_next = shift_reg;
        if (cmd.tick && phase_reg != alsd_pkg::PH_IDLE)
        begin
            if (t1 != 16'd0)
            begin
                timer_next = t1;
            end
            else
            begin
                case (phase_reg)
                    alsd_pkg::PH_HIGH:
                    begin
                        phase_next = alsd_pkg::PH_LOW;
                        timer_next = alsd_pkg::at_least_one(
                                         cur_bit ? one_low_reg : zero_low_reg);
                    end
                    alsd_pkg::PH_LOW:
                    begin
                        if (bit_reg != 3'd0)
                        begin
                            bit_next   = bit_reg - 3'd1;
                            phase_next = alsd_pkg::PH_HIGH;
                            timer_next = alsd_pkg::at_least_one(
                                shift_reg[bit_reg - 3'd1] ? one_high_reg : zero_high_reg);
                        end
                        else
                        begin
                            led_next  = led_inc;
                            slot_next = slot_inc;
                            if (led_inc < n_eff)
                            begin
                                // next byte comes from the store
                                timer_next = 16'd0;
                            end
                            else
                            begin
                                phase_next = alsd_pkg::PH_LATCH;
                                timer_next = alsd_pkg::at_least_one(latch_reg);
                            end
                        end
                    end
                    alsd_pkg::PH_LATCH:
                    begin
                        phase_next = alsd_pkg::PH_IDLE;
                        timer_next = 16'd0;
                        bit_next   = alsd_pkg::BIT_MSB;
                        led_next   = '0;
                        slot_next  = 2'd0;
                    end
                    default:
                    begin
                        phase_next = phase_reg;
                    end
                endcase
            end
        end
        if (cmd.show)
        begin
            led_next  = '0;
            slot_next = 2'd0;
            if (n_eff == '0)
            begin
                phase_next = alsd_pkg::PH_LATCH;
                timer_next = alsd_pkg::at_least_one(latch_reg);
            end
        end
        if (cmd.load)
        begin
            shift_next = rd_data_reg;
            bit_next   = alsd_pkg::BIT_MSB;
            phase_next = alsd_pkg::PH_HIGH;
            timer_next = alsd_pkg::at_least_one(
                             rd_data_reg[7] ? one_high_reg : zero_high_reg);
        end
    end

    always_comb
    begin
        if (alsd_pkg::req_t'(in_req) != alsd_pkg::REQ_TICK
            && phase_reg != alsd_pkg::PH_IDLE)
        begin
            status_now = alsd_pkg::ST_REFUSED;
        end
        else if (alsd_pkg::req_t'(in_req) == alsd_pkg::REQ_SET && stat.idx_bad)
        begin
            status_now = alsd_pkg::ST_BAD_INDEX;
        end
        else
        begin
            status_now = alsd_pkg::ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strip_length_reg <= alsd_pkg::RST_STRIP_LENGTH;
            color_order_reg  <= alsd_pkg::RST_COLOR_ORDER;
            zero_high_reg    <= alsd_pkg::RST_ZERO_HIGH;
            zero_low_reg     <= alsd_pkg::RST_ZERO_LOW;
            one_high_reg     <= alsd_pkg::RST_ONE_HIGH;
            one_low_reg      <= alsd_pkg::RST_ONE_LOW;
            latch_reg        <= alsd_pkg::RST_LATCH;
            phase_reg        <= alsd_pkg::PH_IDLE;
            timer_reg        <= 16'd0;
            bit_reg          <= alsd_pkg::BIT_MSB;
            led_reg          <= '0;
            slot_reg         <= 2'd0;
            shift_reg        <= 8'd0;
            clr_ptr_reg      <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    alsd_pkg::REG_STRIP_LENGTH: strip_length_reg <= cfg_data[8:0];
                    alsd_pkg::REG_COLOR_ORDER:  color_order_reg  <= cfg_data[5:0];
                    alsd_pkg::REG_ZERO_HIGH:    zero_high_reg    <= cfg_data;
                    alsd_pkg::REG_ZERO_LOW:     zero_low_reg     <= cfg_data;
                    alsd_pkg::REG_ONE_HIGH:     one_high_reg     <= cfg_data;
                    alsd_pkg::REG_ONE_LOW:      one_low_reg      <= cfg_data;
                    alsd_pkg::REG_LATCH:        latch_reg        <= cfg_data;
                    default:                    latch_reg        <= latch_reg;
                endcase
            end
            phase_reg <= phase_next;
            timer_reg <= timer_next;
            bit_reg   <= bit_next;
            led_reg   <= led_next;
            slot_reg  <= slot_next;
            shift_reg <= shift_next;
            if (cmd.accept)
            begin
                clr_ptr_reg <= '0;
            end
            else if (cmd.clr_step)
            begin
                clr_ptr_reg <= stat.clr_last ? '0 : clr_ptr_reg + AW'(1);
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            idx_reg    <= LW'(in_index);
            red_reg    <= in_red;
            green_reg  <= in_green;
            blue_reg   <= in_blue;
            status_reg <= status_now;
        end
        if (cmd.emit)
        begin
            out_line_reg   <= (phase_next == alsd_pkg::PH_HIGH);
            out_busy_reg   <= (phase_next != alsd_pkg::PH_IDLE);
            out_status_reg <= cmd.accept ? status_now : status_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_line   = out_line_reg;
    assign out_busy   = out_busy_reg;
    assign out_status = out_status_reg;

endmodule

/* design/addressable_led_strip_driver.sv */
// Single-wire addressable LED strip driver, top level.
// Requests: a tick's result is registered and appears in the cycle after acceptance; a tick
//   that starts a new byte reads it from the store first; clear zeroes 3*N bytes (N LEDs).
// Throughput: one request at a time; a tick a cycle while no new byte is loaded and the result stream is not stalled.
// Reset: rst_n async low; control and config registers take their defaults and the 3*MAX_LEDS-byte store
//   is zeroed by a clearing pass, with s_axis_tready low meanwhile.
`include "addressable_led_strip_driver_assert.svh"

module addressable_led_strip_driver #(
    parameter int MAX_LEDS = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    // request stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // led_index[15:0], red[23:16], green[31:24], blue[39:32]
    input  logic [1:0]  s_axis_tuser,   // req_type[1:0]
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // line_level[0], busy_res[1], status[3:2], zero[7:4]
    // register write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    alsd_pkg::cmd_t  cmd;
    alsd_pkg::stat_t stat;
    logic            out_line;
    logic            out_busy;
    logic [1:0]      out_status;

    // registers are always writable; the user writes them between requests
    assign cfg_ready = 1'b1;

    // sequencer: one request at a time, multi-cycle work for set, clear and byte loads
    alsd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_req   (s_axis_tuser),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // store, bit timing and result register
    alsd_dpath #(
        .MAX_LEDS (MAX_LEDS)
    ) u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid && cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_req     (s_axis_tuser),
        .in_index   (s_axis_tdata[15:0]),
        .in_red     (s_axis_tdata[23:16]),
        .in_green   (s_axis_tdata[31:24]),
        .in_blue    (s_axis_tdata[39:32]),
        .cmd        (cmd),
        .stat       (stat),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_line   (out_line),
        .out_busy   (out_busy),
        .out_status (out_status)
    );

    assign m_axis_tdata = {4'b0000, out_status, out_busy, out_line};

    // a request is only taken when its result has room
    `ALSD_ASSERT_IMP(a_accept_out_free, s_axis_tvalid && s_axis_tready, !m_axis_tvalid || m_axis_tready)
    // the store is only written by set or clear while nothing is being sent
    `ALSD_ASSERT_IMP(a_write_when_idle, cmd.wr_set || (cmd.clr_step && !cmd.clr_all), !stat.busy)
    // a tick with no transmission leaves the line idle
    `ALSD_ASSERT_NXT(a_idle_tick_stays, cmd.tick && !stat.busy, !stat.busy)

endmodule
